### src/rmt_pkg.sv
// ----------------------------------------------------------------------------
// rmt_pkg: shared types and constants for the running median tracker
// Sample and result layouts, the cell link record and the control states.
// ----------------------------------------------------------------------------
package rmt_pkg;

   localparam int SAMPLE_W = 32;  // input sample width
   localparam int MED_W    = 33;  // doubled median width
   localparam int HELD_W   = 7;   // reported sample count width
   localparam int GROUP    = 32;  // cells per first-level select group

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // input transfer payload
   typedef struct packed {
      sample_type sample;
   } req_type;

   // result transfer payload
   typedef struct packed {
      logic signed [MED_W-1:0] median_doubled;
      logic [HELD_W-1:0]       held_total;
      logic                    dropped;
   } rsp_type;

   // what a cell hands to its upper neighbor
   typedef struct packed {
      logic       gt;     // held value is valid and above the new sample
      sample_type value;  // held value
   } link_type;

   // item sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GROUP,
      ST_MERGE,
      ST_SUM
   } state_type;

endpackage

### src/rmt_stream_if.sv
// ----------------------------------------------------------------------------
// rmt_stream_if: valid/ready stream channel
// Carries one payload per transfer; a transfer happens when valid and ready
// are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface rmt_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### src/running_median_tracker.sv
// ----------------------------------------------------------------------------
// running_median_tracker: running median over a stream of signed samples
// Keeps accepted samples sorted in a chain of cells and reports twice the
// median of all held samples after every input transfer.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                  transfer on
//   req_if   in   sample (s32)                             valid && ready
//   rsp_if   out  median_doubled (s33), held_total (u7),   valid && ready
//                 dropped (u1)
//
// One item at a time: the insert into the chain, two levels of the
// registered middle-entry select tree, then the add into the output register.
// The output register lets the next sample come in while a result waits.
// A result that is held back by rsp_if.ready stalls the add stage and req_if.
// Reset (synchronous, active high) empties the store; cell contents are not
// cleared and are never read before being written.
//
module running_median_tracker #(
   parameter int CAPACITY = 64
) (
   input  logic         clock,
   input  logic         reset,
   rmt_stream_if.sink   req_if,
   rmt_stream_if.source rsp_if
);

   localparam int CW = $clog2(CAPACITY + 1);

   rmt_pkg::state_type  state_ff;
   rmt_pkg::state_type  state_in;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic                dropped_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rmt_pkg::rsp_type    rsp_data_ff;
   rmt_pkg::rsp_type    rsp_data_in;
   logic                req_xfer;
   logic                full;
   logic                insert;
   logic                group_en;
   logic                merge_en;
   logic                load_out;
   logic                ready;
   rmt_pkg::link_type   links [CAPACITY];
   rmt_pkg::sample_type values [CAPACITY];
   rmt_pkg::sample_type lo_value;
   rmt_pkg::sample_type hi_value;

   assign full     = count_ff >= CW'(CAPACITY);
   assign req_xfer = req_if.valid && ready;
   assign insert   = req_xfer && !full;
   assign req_if.ready = ready;

   // insertion chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      rmt_pkg::link_type left;
      if (i == 0) begin : g_first
         assign left = '0;
      end else begin : g_rest
         assign left = links[i-1];
      end
      rmt_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock  (clock),
         .insert (insert),
         .sample (req_if.payload.sample),
         .count  (count_ff),
         .left   (left),
         .link   (links[i])
      );
      assign values[i] = links[i].value;
   end

   // middle-entry select
   rmt_pick #(
      .CAPACITY (CAPACITY),
      .CW       (CW)
   ) u_pick (
      .clock    (clock),
      .group_en (group_en),
      .merge_en (merge_en),
      .values   (values),
      .count    (count_ff),
      .lo_value (lo_value),
      .hi_value (hi_value)
   );

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer next state and strobes
   always_comb begin
      state_in = state_ff;
      ready    = 1'b0;
      group_en = 1'b0;
      merge_en = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         rmt_pkg::ST_IDLE: begin
            ready = !reset;
            if (req_if.valid) begin
               state_in = rmt_pkg::ST_GROUP;
            end
         end
         rmt_pkg::ST_GROUP: begin
            group_en = 1'b1;
            state_in = rmt_pkg::ST_MERGE;
         end
         rmt_pkg::ST_MERGE: begin
            merge_en = 1'b1;
            state_in = rmt_pkg::ST_SUM;
         end
         rmt_pkg::ST_SUM: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               load_out = 1'b1;
               state_in = rmt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rmt_pkg::ST_IDLE;
         end
      endcase
   end

   // sample count
   assign count_in = insert ? count_ff + CW'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // drop flag travels with the item
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         dropped_ff <= full;
      end
   end

   // result: exact sum of the two middle entries
   always_comb begin
      rsp_data_in.median_doubled = {lo_value[rmt_pkg::SAMPLE_W-1], lo_value}
                                 + {hi_value[rmt_pkg::SAMPLE_W-1], hi_value};
      rsp_data_in.held_total     = rmt_pkg::HELD_W'(count_ff);
      rsp_data_in.dropped        = dropped_ff;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

endmodule

### src/rmt_cell.sv
// ----------------------------------------------------------------------------
// rmt_cell: one slot of the sorted insertion chain
// Holds one sample. On insert, a slot whose value is above the new sample
// (or the first empty slot) takes either its lower neighbor's value, when
// that neighbor is also above, or the new sample itself.
// ----------------------------------------------------------------------------
module rmt_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 7
) (
   input  logic                clock,
   input  logic                insert,     // write a new sample this cycle
   input  rmt_pkg::sample_type sample,
   input  logic [CW-1:0]       count,      // number of held samples
   input  rmt_pkg::link_type   left,       // lower neighbor
   output rmt_pkg::link_type   link        // to upper neighbor
);

   rmt_pkg::sample_type value_ff;
   rmt_pkg::sample_type value_in;
   logic                occupied;
   logic                take;

   // compare against the new sample
   assign occupied   = CW'(INDEX) < count;
   assign link.gt    = occupied && (value_ff > sample);
   assign link.value = value_ff;
   assign take       = link.gt || (CW'(INDEX) == count);

   // shift up from below or accept the new sample
   always_comb begin
      value_in = value_ff;
      if (take) begin
         value_in = left.gt ? left.value : sample;
      end
   end

   always_ff @(posedge clock) begin
      if (insert) begin
         value_ff <= value_in;
      end
   end

endmodule

### src/rmt_pick.sv
// ----------------------------------------------------------------------------
// rmt_pick: middle-entry select
// Pulls the two middle entries out of the chain through a two-level
// registered OR tree: groups of cells first, then the group results.
// ----------------------------------------------------------------------------
module rmt_pick #(
   parameter int CAPACITY = 64,
   parameter int CW       = 7
) (
   input  logic                clock,
   input  logic                group_en,              // load group registers
   input  logic                merge_en,              // load final registers
   input  rmt_pkg::sample_type values [CAPACITY],
   input  logic [CW-1:0]       count,
   output rmt_pkg::sample_type lo_value,
   output rmt_pkg::sample_type hi_value
);

   localparam int IW = $clog2(CAPACITY);
   localparam int NG = (CAPACITY + rmt_pkg::GROUP - 1) / rmt_pkg::GROUP;

   logic [IW-1:0]       lo_idx;
   logic [IW-1:0]       hi_idx;
   rmt_pkg::sample_type lo_grp_ff [NG];
   rmt_pkg::sample_type hi_grp_ff [NG];
   rmt_pkg::sample_type lo_grp_in [NG];
   rmt_pkg::sample_type hi_grp_in [NG];
   rmt_pkg::sample_type lo_ff;
   rmt_pkg::sample_type hi_ff;
   rmt_pkg::sample_type lo_in;
   rmt_pkg::sample_type hi_in;

   // middle positions; equal for an odd count
   assign lo_idx = IW'((count - CW'(1)) >> 1);
   assign hi_idx = IW'(count >> 1);

   // first level: masked OR inside each group
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         lo_grp_in[g] = '0;
         hi_grp_in[g] = '0;
         for (int j = 0; j < rmt_pkg::GROUP; j++) begin
            if (g * rmt_pkg::GROUP + j < CAPACITY) begin
               if (IW'(g * rmt_pkg::GROUP + j) == lo_idx) begin
                  lo_grp_in[g] = lo_grp_in[g] | values[g * rmt_pkg::GROUP + j];
               end
               if (IW'(g * rmt_pkg::GROUP + j) == hi_idx) begin
                  hi_grp_in[g] = hi_grp_in[g] | values[g * rmt_pkg::GROUP + j];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (group_en) begin
         lo_grp_ff <= lo_grp_in;
         hi_grp_ff <= hi_grp_in;
      end
   end

   // second level: OR across groups
   always_comb begin
      lo_in = '0;
      hi_in = '0;
      for (int g = 0; g < NG; g++) begin
         lo_in = lo_in | lo_grp_ff[g];
         hi_in = hi_in | hi_grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (merge_en) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   assign lo_value = lo_ff;
   assign hi_value = hi_ff;

endmodule
